// File: sv/gps_pkg.sv
// ----------------------------------------------------------------------------
// gps_pkg
// Shared types, codes and constants for the gait phase sequencer.
// ----------------------------------------------------------------------------
package gps_pkg;

    localparam int MAX_PHASES_DEF = 16;
    localparam int NUM_LEGS       = 4;
    localparam int SLOTS          = 4;

    localparam logic [2:0]  LEG_LIMIT     = 3'((NUM_LEGS < SLOTS) ? NUM_LEGS : SLOTS);
    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

    localparam logic [1:0] CFG_PHASE_COUNT = 2'd0;
    localparam logic [1:0] CFG_LOOP_ENABLE = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_MS  = 2'd2;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_START    = 3'd1,
        OP_STOP     = 3'd2,
        OP_LOAD_LEG = 3'd3,
        OP_LOAD_HDR = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_STATUS   = 2'd0,
        KIND_SET      = 2'd1,
        KIND_STOP_LEG = 2'd2,
        KIND_STOP_ALL = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DECIDE,
        S_STOP,
        S_APPLY,
        S_STOP_ALL,
        S_STATUS
    } state_t;

    typedef struct packed {
        logic  capture;
        logic  init_run;
        logic  exec_load;
        logic  stop_run;
        logic  do_start;
        logic  scan_eval;
        logic  decide;
        logic  slot_inc;
        logic  slot_clr;
        logic  stop_pop;
        logic  emit;
        kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       active;
        logic       eff_zero;
        logic       hdr_count_zero;
        logic       slot_last;
        logic       stop_any;
        logic       apply;
    } sts_t;

endpackage

// File: sv/gps_ctrl.sv
// ----------------------------------------------------------------------------
// gps_ctrl
// Sequencing state machine: decode, entry walk, phase decision, result beats.
// ----------------------------------------------------------------------------
module gps_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  gps_pkg::sts_t  sts,
    output gps_pkg::cmd_t  cmd
);

    gps_pkg::state_t state_reg;
    gps_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gps_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = gps_pkg::KIND_STATUS;
        case (state_reg)
            gps_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = gps_pkg::S_EXEC;
                end
            end
            gps_pkg::S_EXEC:
            begin
                cmd.init_run = 1'b1;
                case (sts.op)
                    gps_pkg::OP_TICK:
                    begin
                        if (!sts.active)
                        begin
                            state_next = gps_pkg::S_STATUS;
                        end
                        else if (sts.hdr_count_zero)
                        begin
                            state_next = gps_pkg::S_DECIDE;
                        end
                        else
                        begin
                            cmd.slot_inc = 1'b1;
                            state_next   = gps_pkg::S_SCAN;
                        end
                    end
                    gps_pkg::OP_START:
                    begin
                        if (sts.eff_zero)
                        begin
                            state_next = gps_pkg::S_STATUS;
                        end
                        else
                        begin
                            cmd.do_start = 1'b1;
                            state_next   = gps_pkg::S_STOP;
                        end
                    end
                    gps_pkg::OP_STOP:
                    begin
                        cmd.stop_run = 1'b1;
                        state_next   = gps_pkg::S_STOP_ALL;
                    end
                    gps_pkg::OP_LOAD_LEG, gps_pkg::OP_LOAD_HDR:
                    begin
                        cmd.exec_load = 1'b1;
                        state_next    = gps_pkg::S_STATUS;
                    end
                    default:
                    begin
                        state_next = gps_pkg::S_STATUS;
                    end
                endcase
            end
            gps_pkg::S_SCAN:
            begin
                cmd.scan_eval = 1'b1;
                cmd.slot_inc  = 1'b1;
                if (sts.slot_last)
                begin
                    state_next = gps_pkg::S_DECIDE;
                end
            end
            gps_pkg::S_DECIDE:
            begin
                cmd.decide   = 1'b1;
                cmd.slot_clr = 1'b1;
                state_next   = gps_pkg::S_STOP;
            end
            gps_pkg::S_STOP:
            begin
                if (sts.stop_any)
                begin
                    cmd.emit     = 1'b1;
                    cmd.kind     = gps_pkg::KIND_STOP_LEG;
                    cmd.stop_pop = 1'b1;
                end
                else if (sts.apply)
                begin
                    cmd.slot_inc = 1'b1;
                    state_next   = gps_pkg::S_APPLY;
                end
                else
                begin
                    state_next = gps_pkg::S_STATUS;
                end
            end
            gps_pkg::S_APPLY:
            begin
                if (sts.hdr_count_zero)
                begin
                    state_next = gps_pkg::S_STATUS;
                end
                else
                begin
                    cmd.emit     = 1'b1;
                    cmd.kind     = gps_pkg::KIND_SET;
                    cmd.slot_inc = 1'b1;
                    if (sts.slot_last)
                    begin
                        state_next = gps_pkg::S_STATUS;
                    end
                end
            end
            gps_pkg::S_STOP_ALL:
            begin
                cmd.emit   = 1'b1;
                cmd.kind   = gps_pkg::KIND_STOP_ALL;
                state_next = gps_pkg::S_STATUS;
            end
            gps_pkg::S_STATUS:
            begin
                cmd.emit     = 1'b1;
                cmd.kind     = gps_pkg::KIND_STATUS;
                cmd.slot_clr = 1'b1;
                state_next   = gps_pkg::S_IDLE;
            end
            default:
            begin
                state_next = gps_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != gps_pkg::S_IDLE);

    a_idle_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gps_pkg::S_IDLE) |-> !cmd.emit)
        else $error("result beat issued while idle");

    a_exec_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gps_pkg::S_EXEC) |-> ($past(state_reg) == gps_pkg::S_IDLE))
        else $error("decode entered without an accepted item");

    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gps_pkg::S_SCAN) |=>
        (state_reg == gps_pkg::S_SCAN || state_reg == gps_pkg::S_DECIDE))
        else $error("entry scan left without a phase decision");

    a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gps_pkg::S_STATUS) |=> (state_reg == gps_pkg::S_IDLE))
        else $error("status beat not followed by idle");

    a_stop_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gps_pkg::S_STOP && !sts.stop_any && !sts.apply) |=>
        (state_reg == gps_pkg::S_STATUS))
        else $error("stop drain did not close the run");

endmodule

// File: sv/gps_datapath.sv
// ----------------------------------------------------------------------------
// gps_datapath
// Phase tables, run state, configuration registers and result beat register.
// ----------------------------------------------------------------------------
module gps_datapath #(
    parameter int MAX_PHASES = gps_pkg::MAX_PHASES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  gps_pkg::cmd_t      cmd,
    output gps_pkg::sts_t      sts,
    input  logic [2:0]         opcode,
    input  logic [31:0]        now_ms,
    input  logic [3:0]         moving_mask,
    input  logic [3:0]         load_phase,
    input  logic [1:0]         load_slot,
    input  logic [1:0]         load_leg,
    input  logic signed [15:0] load_hip,
    input  logic signed [15:0] load_knee,
    input  logic [6:0]         load_speed,
    input  logic [2:0]         load_leg_count,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               result_valid,
    output logic [1:0]         kind,
    output logic [1:0]         leg,
    output logic signed [15:0] hip_target,
    output logic signed [15:0] knee_target,
    output logic [6:0]         speed,
    output logic               running,
    output logic [3:0]         current_phase,
    output logic               last
);

    localparam int PW     = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
    localparam int EDEPTH = MAX_PHASES * gps_pkg::SLOTS;

    // captured item
    logic [2:0]  op_reg;
    logic [31:0] now_reg;
    logic [3:0]  mask_reg;
    logic [3:0]  lp_reg;
    logic [1:0]  slot_in_reg;
    logic [1:0]  leg_in_reg;
    logic [15:0] hip_in_reg;
    logic [15:0] knee_in_reg;
    logic [6:0]  speed_in_reg;
    logic [2:0]  cnt_in_reg;

    // configuration
    logic [4:0]  phase_count_reg;
    logic        loop_enable_reg;
    logic [15:0] timeout_ms_reg;

    // run state
    logic          active_reg;
    logic [PW-1:0] phase_reg;
    logic [31:0]   start_ms_reg;
    logic [1:0]    slot_reg;
    logic [1:0]    slot_d_reg;
    logic          settled_reg;
    logic          timed_reg;
    logic          apply_reg;
    logic          elapsed_ge_reg;
    logic [3:0]    stop_flag_reg;
    logic [1:0]    stop_leg_reg [gps_pkg::SLOTS];

    // tables
    logic [9:0]  hdr_mem [MAX_PHASES];
    logic [33:0] ent_mem [EDEPTH];
    logic [9:0]  hdr_q_reg;
    logic [33:0] ent_q_reg;

    // result beat
    logic        result_valid_reg;
    logic [1:0]  kind_reg;
    logic [1:0]  leg_reg;
    logic [15:0] hip_reg;
    logic [15:0] knee_reg;
    logic [6:0]  speed_reg;
    logic        running_reg;
    logic [3:0]  phase_out_reg;
    logic        last_reg;

    logic          lp_ok;
    logic [PW-1:0] lp_addr;
    logic          hdr_we;
    logic          ent_we;
    logic [2:0]    cnt_sat;
    logic [2:0]    hdr_count;
    logic [4:0]    eff_cnt;
    logic [PW:0]   next_idx;
    logic          wrap;
    logic          advance;
    logic [1:0]    ent_leg;
    logic          moving;
    logic [1:0]    stop_pick;

    assign lp_ok     = (32'(lp_reg) < MAX_PHASES);
    assign lp_addr   = PW'(lp_reg);
    assign hdr_we    = cmd.exec_load && !active_reg && lp_ok
                       && (op_reg == gps_pkg::OP_LOAD_HDR);
    assign ent_we    = cmd.exec_load && !active_reg && lp_ok
                       && (op_reg == gps_pkg::OP_LOAD_LEG);
    assign cnt_sat   = (cnt_in_reg > gps_pkg::LEG_LIMIT) ? gps_pkg::LEG_LIMIT : cnt_in_reg;
    assign hdr_count = hdr_q_reg[2:0];
    assign eff_cnt   = (32'(phase_count_reg) > MAX_PHASES) ? 5'(MAX_PHASES)
                                                           : phase_count_reg;
    assign next_idx  = {1'b0, phase_reg} + 1'b1;
    assign wrap      = (32'(next_idx) >= 32'(eff_cnt));
    assign advance   = settled_reg || timed_reg;
    assign ent_leg   = ent_q_reg[33:32];
    assign moving    = mask_reg[ent_leg];

    always_comb
    begin
        stop_pick = '0;
        for (int i = gps_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (stop_flag_reg[i])
            begin
                stop_pick = 2'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= opcode;
            now_reg      <= now_ms;
            mask_reg     <= moving_mask;
            lp_reg       <= load_phase;
            slot_in_reg  <= load_slot;
            leg_in_reg   <= load_leg;
            hip_in_reg   <= load_hip;
            knee_in_reg  <= load_knee;
            speed_in_reg <= load_speed;
            cnt_in_reg   <= load_leg_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_count_reg <= '0;
            loop_enable_reg <= 1'b0;
            timeout_ms_reg  <= gps_pkg::TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gps_pkg::CFG_PHASE_COUNT: phase_count_reg <= cfg_data[4:0];
                gps_pkg::CFG_LOOP_ENABLE: loop_enable_reg <= cfg_data[0];
                gps_pkg::CFG_TIMEOUT_MS:  timeout_ms_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_mem[lp_addr] <= {speed_in_reg, cnt_sat};
        end
        hdr_q_reg <= hdr_mem[phase_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[{lp_addr, slot_in_reg}] <= {leg_in_reg, hip_in_reg, knee_in_reg};
        end
        ent_q_reg  <= ent_mem[{phase_reg, slot_reg}];
        slot_d_reg <= slot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            phase_reg     <= '0;
            start_ms_reg  <= '0;
            slot_reg      <= '0;
            settled_reg   <= 1'b1;
            timed_reg     <= 1'b0;
            apply_reg     <= 1'b0;
            stop_flag_reg <= '0;
        end
        else
        begin
            if (cmd.slot_clr)
            begin
                slot_reg <= '0;
            end
            else if (cmd.slot_inc)
            begin
                slot_reg <= slot_reg + 2'd1;
            end

            if (cmd.init_run)
            begin
                settled_reg   <= 1'b1;
                timed_reg     <= 1'b0;
                stop_flag_reg <= '0;
                apply_reg     <= cmd.do_start;
            end

            if (cmd.do_start)
            begin
                active_reg   <= 1'b1;
                phase_reg    <= '0;
                start_ms_reg <= now_reg;
            end

            if (cmd.stop_run)
            begin
                active_reg <= 1'b0;
            end

            if (cmd.scan_eval && moving)
            begin
                if (elapsed_ge_reg)
                begin
                    timed_reg                 <= 1'b1;
                    stop_flag_reg[slot_d_reg] <= 1'b1;
                end
                else
                begin
                    settled_reg <= 1'b0;
                end
            end

            if (cmd.stop_pop)
            begin
                stop_flag_reg[stop_pick] <= 1'b0;
            end

            if (cmd.decide && advance)
            begin
                if (wrap && !loop_enable_reg)
                begin
                    active_reg <= 1'b0;
                end
                else
                begin
                    phase_reg    <= wrap ? '0 : next_idx[PW-1:0];
                    start_ms_reg <= now_reg;
                    apply_reg    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_run)
        begin
            elapsed_ge_reg <= ((now_reg - start_ms_reg) >= {16'd0, timeout_ms_reg});
        end
        if (cmd.scan_eval && moving && elapsed_ge_reg)
        begin
            stop_leg_reg[slot_d_reg] <= ent_leg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg      <= cmd.kind;
            running_reg   <= active_reg;
            phase_out_reg <= 4'(phase_reg);
            last_reg      <= (cmd.kind == gps_pkg::KIND_STATUS);
            case (cmd.kind)
                gps_pkg::KIND_SET:
                begin
                    leg_reg   <= ent_leg;
                    hip_reg   <= ent_q_reg[31:16];
                    knee_reg  <= ent_q_reg[15:0];
                    speed_reg <= hdr_q_reg[9:3];
                end
                gps_pkg::KIND_STOP_LEG:
                begin
                    leg_reg   <= stop_leg_reg[stop_pick];
                    hip_reg   <= '0;
                    knee_reg  <= '0;
                    speed_reg <= '0;
                end
                default:
                begin
                    leg_reg   <= '0;
                    hip_reg   <= '0;
                    knee_reg  <= '0;
                    speed_reg <= '0;
                end
            endcase
        end
    end

    assign sts.op             = op_reg;
    assign sts.active         = active_reg;
    assign sts.eff_zero       = (eff_cnt == 5'd0);
    assign sts.hdr_count_zero = (hdr_count == 3'd0);
    assign sts.slot_last      = (({1'b0, slot_d_reg} + 3'd1) >= hdr_count);
    assign sts.stop_any       = |stop_flag_reg;
    assign sts.apply          = apply_reg;

    assign cfg_ready     = 1'b1;
    assign result_valid  = result_valid_reg;
    assign kind          = kind_reg;
    assign leg           = leg_reg;
    assign hip_target    = $signed(hip_reg);
    assign knee_target   = $signed(knee_reg);
    assign speed         = speed_reg;
    assign running       = running_reg;
    assign current_phase = phase_out_reg;
    assign last          = last_reg;

endmodule

// File: sv/gait_phase_sequencer.sv
// ----------------------------------------------------------------------------
// gait_phase_sequencer
// Gait phase table with timed phase advance and leg command beats.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the closing status beat has been issued. Results come out one beat a
// cycle on result_valid, which the receiver must take as it comes. Loads,
// unknown opcodes and idle ticks give only the closing status beat; a tick
// that scans four entries, stops four legs and applies a new phase runs
// longest: the leg entry table has one registered read port, so entries are
// walked one per cycle, once to check the moving flags and once to issue
// set-target beats. Tables need loading before use; there is no clearing
// pass. Configuration writes are always ready.
// ----------------------------------------------------------------------------
module gait_phase_sequencer #(
    parameter int MAX_PHASES = gps_pkg::MAX_PHASES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         opcode,
    input  logic [31:0]        now_ms,
    input  logic [3:0]         moving_mask,
    input  logic [3:0]         load_phase,
    input  logic [1:0]         load_slot,
    input  logic [1:0]         load_leg,
    input  logic signed [15:0] load_hip,
    input  logic signed [15:0] load_knee,
    input  logic [6:0]         load_speed,
    input  logic [2:0]         load_leg_count,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               result_valid,
    output logic [1:0]         kind,
    output logic [1:0]         leg,
    output logic signed [15:0] hip_target,
    output logic signed [15:0] knee_target,
    output logic [6:0]         speed,
    output logic               running,
    output logic [3:0]         current_phase,
    output logic               last
);

    gps_pkg::cmd_t cmd;
    gps_pkg::sts_t sts;

    gps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    gps_datapath #(
        .MAX_PHASES (MAX_PHASES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .opcode         (opcode),
        .now_ms         (now_ms),
        .moving_mask    (moving_mask),
        .load_phase     (load_phase),
        .load_slot      (load_slot),
        .load_leg       (load_leg),
        .load_hip       (load_hip),
        .load_knee      (load_knee),
        .load_speed     (load_speed),
        .load_leg_count (load_leg_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .kind           (kind),
        .leg            (leg),
        .hip_target     (hip_target),
        .knee_target    (knee_target),
        .speed          (speed),
        .running        (running),
        .current_phase  (current_phase),
        .last           (last)
    );

endmodule
